### hw/rtl/ssc_pkg.sv
// Shared types, constants and tables for the sun sensor cell current pipeline.
package ssc_pkg;

  localparam int VECTOR_BITS_DEF  = 16;
  localparam int CURRENT_BITS_DEF = 16;
  localparam int EXP_BITS         = 12;
  localparam int BAFFLE_BITS      = 16;
  localparam int D_BITS           = 16;   // clamped dot, Q1.15 in [0, 32768]
  localparam int R_BITS           = 17;   // Q0.16 values in [0, 65536]
  localparam int CFG_IDX_BITS     = 3;

  localparam logic [R_BITS-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NORMAL_X    = 3'd0,
    REG_NORMAL_Y    = 3'd1,
    REG_NORMAL_Z    = 3'd2,
    REG_MAX_CURRENT = 3'd3,
    REG_INC_EXP     = 3'd4
  } cfg_idx_t;

  // sideband that rides along with every word
  typedef struct packed {
    logic                   behind;
    logic [D_BITS-1:0]      d;
    logic [BAFFLE_BITS-1:0] baffle;
  } ssc_item_t;

  // 2^(-2^-(k+1)) in Q0.16
  function automatic logic [15:0] exp_tab(input logic [2:0] k);
    logic [15:0] v;
    case (k)
      3'd0:    v = 16'd46341;
      3'd1:    v = 16'd55110;
      3'd2:    v = 16'd60097;
      3'd3:    v = 16'd62757;
      3'd4:    v = 16'd64132;
      3'd5:    v = 16'd64830;
      3'd6:    v = 16'd65182;
      default: v = 16'd65359;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/ssc_pipe_ctl.sv
// Valid tracking and per-stage load enables for a bubble-collapsing pipeline segment.
module ssc_pipe_ctl #(
  parameter int STAGES = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAGES-1:0] en
);

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;

  // a stage loads when empty or when the stage after it moves
  always_comb begin
    en[STAGES-1] = ~vld_r[STAGES-1] | out_ready;
    for (int s = STAGES - 2; s >= 0; s--) begin
      en[s] = ~vld_r[s] | en[s+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int s = 1; s < STAGES; s++) begin
      if (en[s]) begin
        vld_nxt[s] = vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[STAGES-1];

endmodule

### hw/rtl/ssc_dot.sv
// Dot product of sun direction and cell normal, clamp and rounding to Q1.15.
module ssc_dot import ssc_pkg::*; #(
  parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VECTOR_BITS-1:0] sun_x,
  input  logic signed [VECTOR_BITS-1:0] sun_y,
  input  logic signed [VECTOR_BITS-1:0] sun_z,
  input  logic [BAFFLE_BITS-1:0]        baffle,
  input  logic signed [VECTOR_BITS-1:0] normal_x,
  input  logic signed [VECTOR_BITS-1:0] normal_y,
  input  logic signed [VECTOR_BITS-1:0] normal_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssc_item_t                     out_item
);

  localparam int PW  = 2 * VECTOR_BITS;
  localparam int SH  = 2 * (VECTOR_BITS - 1) - 30;
  localparam int SHR = (SH > 0) ? SH : 0;
  localparam int SHL = (SH < 0) ? -SH : 0;

  logic [1:0] en;

  logic signed [PW-1:0]    px_r, py_r, pz_r;
  logic [BAFFLE_BITS-1:0]  baffle_r;
  ssc_item_t               item_r;
  ssc_item_t               item_nxt;

  logic signed [32:0] tx, ty, tz;
  logic signed [34:0] sum;
  logic [30:0]        dc;
  logic [31:0]        dr;

  ssc_pipe_ctl #(.STAGES(2)) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_r     <= PW'(normal_x) * PW'(sun_x);
      py_r     <= PW'(normal_y) * PW'(sun_y);
      pz_r     <= PW'(normal_z) * PW'(sun_z);
      baffle_r <= baffle;
    end
  end

  // Q2.30 terms, floor rounding
  assign tx = 33'(px_r >>> SHR) <<< SHL;
  assign ty = 33'(py_r >>> SHR) <<< SHL;
  assign tz = 33'(pz_r >>> SHR) <<< SHL;

  always_comb begin
    sum = 35'(tx) + 35'(ty) + 35'(tz);
    dc  = (sum > 35'sd1073741824) ? 31'd1073741824 : sum[30:0];
    dr  = (32'(dc) + 32'd16384) >> 15;
    item_nxt.behind = (sum <= 35'sd0);
    item_nxt.d      = item_nxt.behind ? '0 : dr[D_BITS-1:0];
    item_nxt.baffle = baffle_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      item_r <= item_nxt;
    end
  end

  assign out_item = item_r;

endmodule

### hw/rtl/ssc_acos.sv
// Incidence ratio r = 2*acos(x)/pi: staged square root times a Horner polynomial.
module ssc_acos import ssc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssc_item_t         in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ssc_item_t         out_item,
  output logic [R_BITS-1:0] out_r
);

  localparam int ISQ_ITERS = 17;
  localparam int ISQ_PER   = 3;
  localparam int ISQ_ST    = (ISQ_ITERS + ISQ_PER - 1) / ISQ_PER;
  localparam int STAGES    = ISQ_ST + 1;

  typedef struct packed {
    ssc_item_t         item;
    logic [33:0]       v;
    logic [33:0]       res;
    logic [R_BITS-1:0] x;
    logic [15:0]       poly;
    logic [R_BITS-1:0] r;
  } ac_t;

  logic [STAGES-1:0] en;
  ac_t st_r   [STAGES];
  ac_t st_nxt [STAGES];

  ssc_pipe_ctl #(.STAGES(STAGES)) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    ac_t src;

    if (s == 0) begin : g_src0
      logic [R_BITS-1:0] x0;
      assign x0 = {in_item.d, 1'b0};
      always_comb begin
        src      = '0;
        src.item = in_item;
        src.x    = x0;
        src.v    = {1'b0, ONE_Q16 - x0, 16'd0};
      end
    end else begin : g_srcn
      assign src = st_r[s-1];
    end

    if (s < ISQ_ST) begin : g_sqrt
      always_comb begin
        logic [33:0] vv;
        logic [33:0] rr;
        logic [33:0] bv;
        logic [33:0] pm;
        vv = src.v;
        rr = src.res;
        bv = '0;
        // up to three restoring square root steps per stage
        for (int j = 0; j < ISQ_PER; j++) begin
          if (s * ISQ_PER + j < ISQ_ITERS) begin
            bv = 34'd1 << (32 - 2 * (s * ISQ_PER + j));
            if (vv >= rr + bv) begin
              vv = vv - (rr + bv);
              rr = (rr >> 1) + bv;
            end else begin
              rr = rr >> 1;
            end
          end
        end
        st_nxt[s]     = src;
        st_nxt[s].v   = vv;
        st_nxt[s].res = rr;
        pm = '0;
        if (s == 0) begin
          pm = 34'd781 * 34'(src.x);
          st_nxt[s].poly = 16'(34'd3098 - (pm >> 16));
        end else if (s == 1) begin
          pm = 34'(src.poly) * 34'(src.x);
          st_nxt[s].poly = 16'(34'd8850 - (pm >> 16));
        end else if (s == 2) begin
          pm = 34'(src.poly) * 34'(src.x);
          st_nxt[s].poly = 16'(34'd65533 - (pm >> 16));
        end
      end
    end else begin : g_mul
      always_comb begin
        logic [33:0] pr;
        logic [17:0] rq;
        pr = 34'(src.res[16:0]) * 34'(src.poly) + 34'd32768;
        rq = pr[33:16];
        st_nxt[s]   = src;
        st_nxt[s].r = (rq > 18'(ONE_Q16)) ? ONE_Q16 : rq[R_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign out_item = st_r[STAGES-1].item;
  assign out_r    = st_r[STAGES-1].r;

endmodule

### hw/rtl/ssc_pow.sv
// Correction factor 1 - r^e via log2 by repeated squaring and exp2 by table products.
module ssc_pow import ssc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssc_item_t           in_item,
  input  logic [R_BITS-1:0]   in_r,
  input  logic [EXP_BITS-1:0] exponent,
  output logic                out_valid,
  input  logic                out_ready,
  output ssc_item_t           out_item,
  output logic [R_BITS-1:0]   out_factor
);

  localparam int SQ_ST   = 16;
  localparam int ST_MUL  = SQ_ST + 1;
  localparam int ST_RND  = SQ_ST + 2;
  localparam int ST_TAB  = SQ_ST + 3;
  localparam int TAB_N   = 8;
  localparam int ST_FIN  = ST_TAB + TAB_N;
  localparam int STAGES  = ST_FIN + 1;

  typedef struct packed {
    ssc_item_t         item;
    logic              one_f;
    logic              zero_f;
    logic              under_f;
    logic [3:0]        n;
    logic [R_BITS-1:0] x;
    logic [15:0]       frac;
    logic [33:0]       ety;
    logic [4:0]        ip;
    logic [7:0]        f8;
    logic [R_BITS-1:0] p;
  } pw_t;

  logic [STAGES-1:0] en;
  pw_t st_r   [STAGES];
  pw_t st_nxt [STAGES];

  ssc_pipe_ctl #(.STAGES(STAGES)) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    pw_t src;

    if (s == 0) begin : g_src0
      always_comb begin
        src      = '0;
        src.item = in_item;
      end
    end else begin : g_srcn
      assign src = st_r[s-1];
    end

    if (s == 0) begin : g_norm
      always_comb begin
        logic [3:0]  nz;
        logic [15:0] m;
        nz = '0;
        for (int i = 0; i < 16; i++) begin
          if (in_r[i]) begin
            nz = 4'(15 - i);
          end
        end
        m = in_r[15:0] << nz;
        st_nxt[s]        = src;
        st_nxt[s].one_f  = (exponent == '0) || in_r[16];
        st_nxt[s].zero_f = (in_r == '0);
        st_nxt[s].n      = nz;
        st_nxt[s].x      = {m, 1'b0};
      end
    end else if (s <= SQ_ST) begin : g_sq
      always_comb begin
        logic [33:0] sq;
        sq = 34'(src.x) * 34'(src.x);
        st_nxt[s] = src;
        if (sq[33]) begin
          st_nxt[s].x             = sq[33:17];
          st_nxt[s].frac[16 - s]  = 1'b1;
        end else begin
          st_nxt[s].x = sq[32:16];
        end
      end
    end else if (s == ST_MUL) begin : g_mul
      always_comb begin
        logic [20:0] t;
        t = {5'(src.n) + 5'd1, 16'd0} - 21'(src.frac);
        st_nxt[s]     = src;
        st_nxt[s].ety = 34'(exponent) * 34'(t);
      end
    end else if (s == ST_RND) begin : g_rnd
      always_comb begin
        logic [25:0] y;
        logic [9:0]  ipw;
        logic [16:0] fr;
        y   = 26'((src.ety + 34'd128) >> 8);
        ipw = y[25:16];
        fr  = 17'(y[15:0]) + 17'd128;
        st_nxt[s]    = src;
        st_nxt[s].f8 = fr[15:8];
        if (fr[16]) begin
          ipw = ipw + 10'd1;
        end
        st_nxt[s].under_f = (ipw >= 10'd17);
        st_nxt[s].ip      = ipw[4:0];
        st_nxt[s].p       = ONE_Q16;
      end
    end else if (s < ST_FIN) begin : g_tab
      always_comb begin
        logic [33:0] pm;
        pm = 34'(src.p) * 34'(exp_tab(3'(s - ST_TAB))) + 34'd32768;
        st_nxt[s] = src;
        if (src.f8[7 - (s - ST_TAB)]) begin
          st_nxt[s].p = pm[32:16];
        end
      end
    end else begin : g_fin
      always_comb begin
        logic [R_BITS-1:0] pw;
        if (src.one_f) begin
          pw = ONE_Q16;
        end else if (src.zero_f || src.under_f) begin
          pw = '0;
        end else begin
          pw = src.p >> src.ip;
        end
        st_nxt[s]   = src;
        st_nxt[s].p = ONE_Q16 - pw;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign out_item   = st_r[STAGES-1].item;
  assign out_factor = st_r[STAGES-1].p;

endmodule

### hw/rtl/ssc_cur.sv
// Current scaling by max current, dot, correction factor and baffle, with saturation.
module ssc_cur import ssc_pkg::*; #(
  parameter int CURRENT_BITS = CURRENT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ssc_item_t               in_item,
  input  logic [R_BITS-1:0]       in_factor,
  input  logic [CURRENT_BITS-1:0] max_current,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CURRENT_BITS-1:0] out_current,
  output logic                    out_behind
);

  localparam int A0W = CURRENT_BITS + D_BITS;
  localparam int P1W = A0W + 18;
  localparam int A1W = A0W + 2;
  localparam int P2W = A1W + 17;
  localparam int A2W = P2W - 30;

  logic [3:0] en;

  ssc_item_t         item0_r, item1_r, item2_r;
  logic [R_BITS-1:0] factor0_r;
  logic [A0W-1:0]    a0_r;
  logic [A1W-1:0]    a1_r;
  logic [A2W-1:0]    a2_r;
  logic [P1W-1:0]    p1;
  logic [P2W-1:0]    p2;
  logic [CURRENT_BITS-1:0] cur_r;
  logic                    behind_r;

  ssc_pipe_ctl #(.STAGES(4)) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  assign p1 = P1W'(a0_r) * P1W'(factor0_r) + P1W'(32768);
  assign p2 = P2W'(a1_r) * P2W'(item1_r.baffle) + P2W'(1 << 29);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0_r      <= A0W'(max_current) * A0W'(in_item.d);
      factor0_r <= in_factor;
      item0_r   <= in_item;
    end
    if (en[1]) begin
      a1_r    <= p1[P1W-1:16];
      item1_r <= item0_r;
    end
    if (en[2]) begin
      a2_r    <= p2[P2W-1:30];
      item2_r <= item1_r;
    end
    if (en[3]) begin
      behind_r <= item2_r.behind;
      if (item2_r.behind) begin
        cur_r <= '0;
      end else if (a2_r > A2W'({CURRENT_BITS{1'b1}})) begin
        cur_r <= '1;
      end else begin
        cur_r <= a2_r[CURRENT_BITS-1:0];
      end
    end
  end

  assign out_current = cur_r;
  assign out_behind  = behind_r;

endmodule

### hw/rtl/sun_sensor_cell_current.sv
// Sun sensor cell current: top level with configuration registers and pipeline segments.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------------
//   in       | in_valid/in_ready   | in_sun_x, in_sun_y, in_sun_z, in_baffle_coefficient
//   out      | out_valid/out_ready | out_measured_current, out_sun_behind
//   cfg      | cfg_we              | cfg_index, cfg_wdata
//
// One word per cycle sustained while out_ready is high; words pass dot, acos, log/exp and scaling in order.
// The log2 squaring chain, one 17x17 multiply per stage, sets the depth.
// rst_n is synchronous; it clears valid bits and loads register reset values.
// Each stage holds when the next is full and stalled; bubbles collapse, so
// in_ready stays high while any stage is empty.
module sun_sensor_cell_current import ssc_pkg::*; #(
  parameter int VECTOR_BITS  = VECTOR_BITS_DEF,
  parameter int CURRENT_BITS = CURRENT_BITS_DEF,
  localparam int CFG_W = (VECTOR_BITS > CURRENT_BITS)
                         ? ((VECTOR_BITS > EXP_BITS) ? VECTOR_BITS : EXP_BITS)
                         : ((CURRENT_BITS > EXP_BITS) ? CURRENT_BITS : EXP_BITS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VECTOR_BITS-1:0] in_sun_x,
  input  logic signed [VECTOR_BITS-1:0] in_sun_y,
  input  logic signed [VECTOR_BITS-1:0] in_sun_z,
  input  logic [BAFFLE_BITS-1:0]        in_baffle_coefficient,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CURRENT_BITS-1:0]       out_measured_current,
  output logic                          out_sun_behind,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata
);

  logic signed [VECTOR_BITS-1:0] normal_x_r, normal_y_r, normal_z_r;
  logic [CURRENT_BITS-1:0]       max_current_r;
  logic [EXP_BITS-1:0]           inc_exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_x_r    <= '0;
      normal_y_r    <= '0;
      normal_z_r    <= VECTOR_BITS'(32767);
      max_current_r <= '0;
      inc_exp_r     <= EXP_BITS'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORMAL_X:    normal_x_r    <= cfg_wdata[VECTOR_BITS-1:0];
        REG_NORMAL_Y:    normal_y_r    <= cfg_wdata[VECTOR_BITS-1:0];
        REG_NORMAL_Z:    normal_z_r    <= cfg_wdata[VECTOR_BITS-1:0];
        REG_MAX_CURRENT: max_current_r <= cfg_wdata[CURRENT_BITS-1:0];
        REG_INC_EXP:     inc_exp_r     <= cfg_wdata[EXP_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic              dot_valid, dot_ready;
  ssc_item_t         dot_item;
  logic              ac_valid, ac_ready;
  ssc_item_t         ac_item;
  logic [R_BITS-1:0] ac_r;
  logic              pw_valid, pw_ready;
  ssc_item_t         pw_item;
  logic [R_BITS-1:0] pw_factor;

  ssc_dot #(.VECTOR_BITS(VECTOR_BITS)) u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sun_x     (in_sun_x),
    .sun_y     (in_sun_y),
    .sun_z     (in_sun_z),
    .baffle    (in_baffle_coefficient),
    .normal_x  (normal_x_r),
    .normal_y  (normal_y_r),
    .normal_z  (normal_z_r),
    .out_valid (dot_valid),
    .out_ready (dot_ready),
    .out_item  (dot_item)
  );

  ssc_acos u_acos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dot_valid),
    .in_ready  (dot_ready),
    .in_item   (dot_item),
    .out_valid (ac_valid),
    .out_ready (ac_ready),
    .out_item  (ac_item),
    .out_r     (ac_r)
  );

  ssc_pow u_pow (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (ac_valid),
    .in_ready   (ac_ready),
    .in_item    (ac_item),
    .in_r       (ac_r),
    .exponent   (inc_exp_r),
    .out_valid  (pw_valid),
    .out_ready  (pw_ready),
    .out_item   (pw_item),
    .out_factor (pw_factor)
  );

  ssc_cur #(.CURRENT_BITS(CURRENT_BITS)) u_cur (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pw_valid),
    .in_ready    (pw_ready),
    .in_item     (pw_item),
    .in_factor   (pw_factor),
    .max_current (max_current_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_current (out_measured_current),
    .out_behind  (out_sun_behind)
  );

  // sun behind the cell always yields zero current
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sun_behind |-> out_measured_current == '0)
    else $error("nonzero current with sun behind");

  // input back-pressure only when the whole pipe is full and the output stalls
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with a bubble in the pipe");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

### dv/sun_sensor_cell_current_tb.sv
// Testbench for the sun sensor cell current pipeline: random and directed words, scoreboard.
`timescale 1ns / 100ps

module sun_sensor_cell_current_tb;
  import ssc_pkg::*;

  localparam int VB = 16;
  localparam int CB = 16;
  localparam int LATENCY = 41;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [CB-1:0] current;
    logic          behind;
  } cell_result_t;

  // configuration mirror and expected-result queue
  class cell_current_board;
    logic signed [VB-1:0] nx, ny, nz;
    logic [CB-1:0]        imax;
    logic [11:0]          expo;
    cell_result_t         pending[$];
    int                   errors;

    function new();
      nx = 0; ny = 0; nz = 16'sd32767; imax = 0; expo = 12'd256; errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_NORMAL_X:    nx = v;
        REG_NORMAL_Y:    ny = v;
        REG_NORMAL_Z:    nz = v;
        REG_MAX_CURRENT: imax = v;
        REG_INC_EXP:     expo = v[11:0];
        default: ;
      endcase
    endfunction

    // product Q2.30 already; floor on shift 0 is identity
    function longint floor_q30(longint p);
      return p;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    function longint unsigned incidence_ratio(longint unsigned x);
      longint unsigned sq, p, r;
      sq = root((64'd65536 - x) << 16);
      p = 64'd3098 - ((64'd781 * x) >> 16);
      p = 64'd8850 - ((p * x) >> 16);
      p = 64'd65533 - ((p * x) >> 16);
      r = (sq * p + 64'd32768) >> 16;
      return (r > 64'd65536) ? 64'd65536 : r;
    endfunction

    function longint unsigned ratio_pow(longint unsigned r, longint unsigned e);
      longint unsigned m, n, x, frac, t, y, ip, f8, p;
      longint unsigned tab[8];
      if (e == 0 || r >= 64'd65536) return 64'd65536;
      if (r == 0) return 0;
      tab = '{46341, 55110, 60097, 62757, 64132, 64830, 65182, 65359};
      m = r; n = 0;
      while (m < 64'd32768) begin
        m <<= 1; n++;
      end
      x = m << 1;
      frac = 0;
      for (int i = 0; i < 16; i++) begin
        x = (x * x) >> 16;
        if (x >= 64'd131072) begin
          x >>= 1; frac |= 64'd1 << (15 - i);
        end
      end
      t = ((n + 1) << 16) - frac;
      y = (e * t + 128) >> 8;
      ip = y >> 16;
      f8 = ((y & 64'hFFFF) + 128) >> 8;
      if (f8 == 256) begin
        ip++; f8 = 0;
      end
      if (ip >= 17) return 0;
      p = 64'd65536;
      for (int k = 0; k < 8; k++)
        if (f8[7-k]) p = (p * tab[k] + 64'd32768) >> 16;
      return p >> ip;
    endfunction

    function void note_sample(logic signed [VB-1:0] sx, sy, sz, logic [15:0] baffle);
      longint dot;
      longint unsigned d, a, factor;
      cell_result_t res;
      dot = floor_q30(longint'(nx) * longint'(sx)) + floor_q30(longint'(ny) * longint'(sy))
          + floor_q30(longint'(nz) * longint'(sz));
      if (dot > (64'sd1 << 30)) dot = 64'sd1 << 30;
      if (dot < -(64'sd1 << 30)) dot = -(64'sd1 << 30);
      if (dot <= 0) begin
        res.current = 0; res.behind = 1;
      end else begin
        d = (longint'(dot) + (1 << 14)) >> 15;
        factor = 64'd65536 - ratio_pow(incidence_ratio(d << 1), expo);
        a = longint'(imax) * d;
        a = (a * factor + 64'd32768) >> 16;
        a = (a * baffle + (64'd1 << 29)) >> 30;
        if (a > 64'hFFFF) a = 64'hFFFF;
        res.current = a[CB-1:0]; res.behind = 0;
      end
      pending.push_back(res);
    endfunction

    function void check_word(logic [CB-1:0] cur, logic behind);
      cell_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected word: measured_current %0d sun_behind %0d", cur, behind);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (cur !== e.current) begin
        $error("measured_current expected %0d actual %0d", e.current, cur);
        errors++;
      end
      if (behind !== e.behind) begin
        $error("sun_behind expected %0d actual %0d", e.behind, behind);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, out_sun_behind;
  logic signed [VB-1:0] in_sun_x = 0, in_sun_y = 0, in_sun_z = 0;
  logic [15:0] in_baffle_coefficient = 0;
  logic [CB-1:0] out_measured_current;
  logic cfg_we = 0;
  logic [CFG_IDX_BITS-1:0] cfg_index = 0;
  logic [15:0] cfg_wdata = 0;

  cell_current_board board = new();
  bit hold_rx = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  sun_sensor_cell_current DUT (.*);

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_sample(in_sun_x, in_sun_y, in_sun_z,
                                                         in_baffle_coefficient);
    if (rst_n && out_valid && out_ready) board.check_word(out_measured_current, out_sun_behind);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall per word, long hold-off when asked
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_rx) begin
        out_ready <= 0;
        @(posedge clk iff !hold_rx);
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk iff (out_valid || hold_rx));
    end
  end

  task automatic send_word(logic [15:0] x, y, z, logic [15:0] b, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 13) : 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1;
    in_sun_x <= x; in_sun_y <= y; in_sun_z <= z; in_baffle_coefficient <= b;
    @(posedge clk iff in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.write_reg(idx, v);
  endtask

  task automatic set_cell(logic [15:0] x, y, z, logic [15:0] imax, logic [11:0] e);
    write_reg(REG_NORMAL_X, x);
    write_reg(REG_NORMAL_Y, y);
    write_reg(REG_NORMAL_Z, z);
    write_reg(REG_MAX_CURRENT, imax);
    write_reg(REG_INC_EXP, {4'd0, e});
  endtask

  // mostly unit-ish vectors near the normal, some raw noise
  task automatic random_word(bit gaps);
    logic [15:0] x, y, z, b;
    if ($urandom_range(0, 3) == 0) begin
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    end else begin
      x = 16'($urandom_range(0, 12000) - 6000);
      y = 16'($urandom_range(0, 12000) - 6000);
      z = 16'($urandom_range(20000, 32767));
      if ($urandom_range(0, 5) == 0) z = -z;
    end
    b = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    send_word(x, y, z, b, gaps);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: normal along z
    set_cell(16'd0, 16'd0, 16'd32767, 16'd65535, 12'd256);
    send_word(16'd0, 16'd0, 16'h7FFF, 16'd32768, 0);       // on axis
    send_word(16'd0, 16'd0, 16'h8000, 16'd32768, 0);       // sun behind
    send_word(16'd0, 16'd0, 16'd0, 16'd32768, 0);          // zero dot
    send_word(16'h7FFF, 16'h8000, 16'd1, 16'd32768, 0);    // grazing
    send_word(16'd0, 16'd0, 16'd23170, 16'd65535, 0);      // baffle above one
    send_word(16'd0, 16'd0, 16'h7FFF, 16'd0, 0);
    send_word(16'hFFFF, 16'hFFFF, 16'd16384, 16'hFFFF, 0);
    drain();
    set_cell(16'd0, 16'd0, 16'd32767, 16'd40000, 12'd0);   // zero exponent
    send_word(16'd0, 16'd0, 16'h7FFF, 16'd32768, 0);
    send_word(16'd0, 16'd0, 16'd5, 16'd32768, 0);
    drain();
    set_cell(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 12'd4095); // dot clamp both ways
    send_word(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 0);
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd32768, 0);
    send_word(16'h8000, 16'd0, 16'd0, 16'd32768, 0);
    drain();
    write_reg(cfg_idx_t'(3'd7), 16'h1234);                 // unknown index, ignored

    // fill the pipeline while the receiver holds off
    set_cell(16'd0, 16'd0, 16'd32767, 16'd30000, 12'd300);
    hold_rx = 1;
    fork
      begin
        repeat (120) @(posedge clk);
        hold_rx = 0;
      end
      repeat (60) random_word(0);
    join
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_cell(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0,
               ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0,
               (ph == 0) ? 16'h7FFF : 16'($urandom_range(16000, 32767)),
               (ph == 1) ? 16'hFFFF : 16'($urandom),
               (ph == 2) ? 12'd4095 : (ph == 3) ? 12'd0 : 12'($urandom_range(0, 1200)));
      for (int i = 0; i < 90; i++) random_word((i / 30) % 2 == 0);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
